// File: rtl/twac_pkg.sv
// Shared constants, codes and controller/datapath interface types for the tree-walk block.
`timescale 1ns / 1ps

package twac_pkg;

   // Bitmap geometry
   localparam int MAX_DEPTH = 10;
   localparam int SLOT_TOTAL = 1 << MAX_DEPTH;
   localparam int SLOT_AW = MAX_DEPTH;
   localparam int ROW_LG = (MAX_DEPTH < 5) ? MAX_DEPTH : 5;
   localparam int ROW_W = 1 << ROW_LG;
   localparam int ROW_CNT = SLOT_TOTAL / ROW_W;
   localparam int ROW_AW = (ROW_CNT > 1) ? $clog2(ROW_CNT) : 1;
   localparam int ROWS_W = ROW_AW + 1;
   localparam int SPAN_W = ROW_LG + 1;

   // Tree level and range stack
   localparam int LVL_W = $clog2(MAX_DEPTH + 1);
   localparam int STK_DEPTH = MAX_DEPTH + 1;
   localparam int STK_IW = $clog2(STK_DEPTH);
   localparam int STK_AW = $clog2(STK_DEPTH + 1);

   // Field widths
   localparam int DEPTH_W = 4;
   localparam int LEAF_W = 10;
   localparam int CNT11_W = 11;
   localparam int CNT10_W = 10;
   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd10;

   // Item action codes
   typedef enum logic [1:0] {
      ACT_MARK  = 2'd0,
      ACT_WALK  = 2'd1,
      ACT_SCAN  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic mark_load;
      logic mark_write;
      logic clear_map;
      logic scan_load;
      logic scan_step;
      logic walk_load;
      logic pop;
      logic walk_step;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic last_row;
      logic range_done;
      logic walk_all_done;
   } sts_type;

endpackage

// File: rtl/twac_ctrl.sv
// Controller state machine: sequences mark, clear, scan and tree-walk items.
`timescale 1ns / 1ps

module twac_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_action,
   input  twac_pkg::sts_type    sts,
   output twac_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 rsp_valid
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK_WR,
      ST_SCAN,
      ST_POP,
      ST_PROBE,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      rsp_valid_ff;
   twac_pkg::action_type act;

   assign act = twac_pkg::action_type'(req_action);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (act)
                  twac_pkg::ACT_MARK: begin
                     cmd.mark_load = 1'b1;
                     state_in = ST_MARK_WR;
                  end
                  twac_pkg::ACT_WALK: begin
                     cmd.walk_load = 1'b1;
                     state_in = ST_POP;
                  end
                  twac_pkg::ACT_SCAN: begin
                     cmd.scan_load = 1'b1;
                     state_in = ST_SCAN;
                  end
                  twac_pkg::ACT_CLEAR: begin
                     cmd.clear_map = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_MARK_WR: begin
            cmd.mark_write = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.last_row) state_in = ST_RESP;
         end
         ST_POP: begin
            cmd.pop = 1'b1;
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            cmd.walk_step = 1'b1;
            if (sts.walk_all_done) state_in = ST_RESP;
            else if (sts.range_done) state_in = ST_POP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff <= (state_in != ST_IDLE);
         rsp_valid_ff <= (state_in == ST_RESP);
      end
   end

   assign busy = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/twac_dp.sv
// Datapath: presence bitmap memory, range stack, depth register and probe tallies.
`timescale 1ns / 1ps

module twac_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  twac_pkg::cmd_type                   cmd,
   output twac_pkg::sts_type                   sts,
   input  logic [twac_pkg::LEAF_W-1:0]         req_leaf_index,
   input  logic                                csr_wr_en,
   input  logic [twac_pkg::DEPTH_W-1:0]        csr_wr_data,
   output logic                                rsp_walk_kind,
   output logic [twac_pkg::CNT11_W-1:0]        rsp_probe_count,
   output logic [twac_pkg::CNT11_W-1:0]        rsp_success_count,
   output logic [twac_pkg::CNT11_W-1:0]        rsp_idle_count,
   output logic [twac_pkg::CNT10_W-1:0]        rsp_collision_count
);

   localparam int ROW_W = twac_pkg::ROW_W;
   localparam int ROW_LG = twac_pkg::ROW_LG;
   localparam int ROW_AW = twac_pkg::ROW_AW;
   localparam int ROW_CNT = twac_pkg::ROW_CNT;
   localparam int ROWS_W = twac_pkg::ROWS_W;
   localparam int SPAN_W = twac_pkg::SPAN_W;
   localparam int LVL_W = twac_pkg::LVL_W;
   localparam int SLOT_AW = twac_pkg::SLOT_AW;
   localparam int STK_DEPTH = twac_pkg::STK_DEPTH;
   localparam int STK_IW = twac_pkg::STK_IW;
   localparam int STK_AW = twac_pkg::STK_AW;
   localparam int C11 = twac_pkg::CNT11_W;
   localparam int C10 = twac_pkg::CNT10_W;
   localparam int LEAF_W1 = twac_pkg::LEAF_W + 1;

   // Rows covered by a range of 2^lvl slots
   function automatic logic [ROWS_W-1:0] rows_of(input logic [LVL_W-1:0] lvl);
      if (lvl >= LVL_W'(ROW_LG)) return ROWS_W'(1) << (lvl - LVL_W'(ROW_LG));
      else return ROWS_W'(1);
   endfunction

   // Slot mask of a range inside one row, aligned to bit 0
   function automatic logic [ROW_W-1:0] span_mask(input logic [LVL_W-1:0] lvl);
      logic [ROW_W:0] m;
      if (lvl >= LVL_W'(ROW_LG)) return '1;
      m = ((ROW_W + 1)'(1) << (ROW_W'(1) << lvl)) - (ROW_W + 1)'(1);
      return m[ROW_W-1:0];
   endfunction

   // Depth register and effective depth
   logic [twac_pkg::DEPTH_W-1:0] depth_ff;
   logic [LVL_W-1:0]             eff_depth;

   always_ff @(posedge clock) begin
      if (reset) depth_ff <= twac_pkg::DEPTH_RESET;
      else if (csr_wr_en) depth_ff <= csr_wr_data;
   end

   assign eff_depth = (depth_ff > twac_pkg::DEPTH_W'(twac_pkg::MAX_DEPTH))
                    ? LVL_W'(twac_pkg::MAX_DEPTH) : depth_ff[LVL_W-1:0];

   // Bitmap memory with per-row valid bits
   logic [ROW_W-1:0]  map_mem [ROW_CNT];
   logic [ROW_CNT-1:0] row_valid_ff;
   logic [ROW_W-1:0]  rd_data_ff;
   logic              rd_valid_ff;
   logic [ROW_W-1:0]  row_data;
   logic [ROW_AW-1:0] cur_row_ff, cur_row_in;

   // Mark item
   logic [ROW_LG-1:0] mark_bit_ff;
   logic              mark_ok_ff;
   logic              mark_ok;
   logic [ROW_W-1:0]  mark_row;

   assign mark_ok = ({1'b0, req_leaf_index} < ((LEAF_W1)'(1) << eff_depth));

   always_ff @(posedge clock) begin
      if (cmd.mark_load) begin
         mark_bit_ff <= req_leaf_index[ROW_LG-1:0];
         mark_ok_ff <= mark_ok;
      end
   end

   assign row_data = rd_valid_ff ? rd_data_ff : '0;
   assign mark_row = row_data | (ROW_W'(1) << mark_bit_ff);

   always_ff @(posedge clock) begin
      if (cmd.mark_write && mark_ok_ff) map_mem[cur_row_ff] <= mark_row;
      rd_data_ff <= map_mem[cur_row_in];
      rd_valid_ff <= row_valid_ff[cur_row_in];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_map) row_valid_ff <= '0;
      else if (cmd.mark_write && mark_ok_ff) row_valid_ff[cur_row_ff] <= 1'b1;
   end

   // Range stack
   logic [SLOT_AW-1:0] stk_base_ff [STK_DEPTH];
   logic [LVL_W-1:0]   stk_lvl_ff  [STK_DEPTH];
   logic [STK_AW-1:0]  stk_top_ff;
   logic [STK_IW-1:0]  pop_idx;
   logic [STK_IW-1:0]  push_idx;
   logic [SLOT_AW-1:0] pop_base;
   logic [LVL_W-1:0]   pop_lvl;

   assign pop_idx = STK_IW'(stk_top_ff - STK_AW'(1));
   assign push_idx = stk_top_ff[STK_IW-1:0];
   assign pop_base = stk_base_ff[pop_idx];
   assign pop_lvl = stk_lvl_ff[pop_idx];

   // Current range being probed
   logic [SLOT_AW-1:0] cur_base_ff;
   logic [LVL_W-1:0]   cur_lvl_ff;
   logic [ROWS_W-1:0]  rows_left_ff;
   logic [1:0]         cnt_ff;

   // Row select for the next read
   always_comb begin
      cur_row_in = cur_row_ff;
      if (cmd.mark_load) cur_row_in = req_leaf_index[SLOT_AW-1:ROW_LG];
      else if (cmd.scan_load) cur_row_in = '0;
      else if (cmd.pop) cur_row_in = pop_base[SLOT_AW-1:ROW_LG];
      else if (cmd.scan_step || cmd.walk_step) cur_row_in = cur_row_ff + ROW_AW'(1);
   end

   always_ff @(posedge clock) cur_row_ff <= cur_row_in;

   // Probe evaluation over one row
   logic [ROW_W-1:0]  walk_bits;
   logic              any_tag, many_tag;
   logic [1:0]        row_n;
   logic [2:0]        sum3;
   logic [1:0]        cnt_new;
   logic              range_done;
   logic              push;
   logic [SLOT_AW-1:0] half;
   logic [ROW_W-1:0]  scan_bits;
   logic [SPAN_W-1:0] scan_pop;
   logic [SPAN_W-1:0] scan_span;

   assign walk_bits = row_data & (span_mask(cur_lvl_ff) << cur_base_ff[ROW_LG-1:0]);
   assign any_tag = |walk_bits;
   assign many_tag = |(walk_bits & (walk_bits - ROW_W'(1)));
   assign row_n = many_tag ? 2'd2 : (any_tag ? 2'd1 : 2'd0);
   assign sum3 = {1'b0, cnt_ff} + {1'b0, row_n};
   assign cnt_new = (sum3 >= 3'd2) ? 2'd2 : sum3[1:0];
   assign range_done = cmd.walk_step && (cnt_new == 2'd2 || rows_left_ff == ROWS_W'(1));
   assign push = range_done && (cnt_new == 2'd2) && (cur_lvl_ff != '0)
              && (({1'b0, stk_top_ff} + (STK_AW + 1)'(2)) <= (STK_AW + 1)'(STK_DEPTH));
   assign half = SLOT_AW'(1) << (cur_lvl_ff - LVL_W'(1));

   assign scan_bits = row_data & span_mask(eff_depth);
   assign scan_pop = SPAN_W'($countones(scan_bits));
   assign scan_span = (eff_depth >= LVL_W'(ROW_LG)) ? SPAN_W'(ROW_W)
                    : (SPAN_W'(1) << eff_depth);

   // Range, stack and row counter control
   always_ff @(posedge clock) begin
      if (reset) begin
         stk_top_ff <= '0;
      end else if (cmd.walk_load) begin
         stk_top_ff <= STK_AW'(1);
      end else if (cmd.pop) begin
         stk_top_ff <= stk_top_ff - STK_AW'(1);
      end else if (push) begin
         stk_top_ff <= stk_top_ff + STK_AW'(2);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_load) begin
         stk_base_ff[0] <= '0;
         stk_lvl_ff[0] <= eff_depth;
      end else if (push) begin
         // upper half below, lower half on top so it is probed first
         stk_base_ff[push_idx] <= cur_base_ff + half;
         stk_lvl_ff[push_idx] <= cur_lvl_ff - LVL_W'(1);
         stk_base_ff[push_idx + STK_IW'(1)] <= cur_base_ff;
         stk_lvl_ff[push_idx + STK_IW'(1)] <= cur_lvl_ff - LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rows_left_ff <= '0;
      end else if (cmd.scan_load) begin
         rows_left_ff <= rows_of(eff_depth);
      end else if (cmd.pop) begin
         cur_base_ff <= pop_base;
         cur_lvl_ff <= pop_lvl;
         rows_left_ff <= rows_of(pop_lvl);
         cnt_ff <= '0;
      end else if (cmd.scan_step || cmd.walk_step) begin
         rows_left_ff <= rows_left_ff - ROWS_W'(1);
         // tag count only tracks the range under probe
         if (cmd.walk_step) cnt_ff <= cnt_new;
      end
   end

   // Tallies
   logic             kind_ff;
   logic [C11-1:0]   probes_ff, success_ff, idle_ff;
   logic [C10-1:0]   coll_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= 1'b0;
         probes_ff <= '0;
         success_ff <= '0;
         idle_ff <= '0;
         coll_ff <= '0;
      end else if (cmd.walk_load || cmd.scan_load) begin
         kind_ff <= cmd.scan_load;
         probes_ff <= '0;
         success_ff <= '0;
         idle_ff <= '0;
         coll_ff <= '0;
      end else if (cmd.scan_step) begin
         probes_ff <= probes_ff + C11'(scan_span);
         success_ff <= success_ff + C11'(scan_pop);
         idle_ff <= idle_ff + C11'(scan_span - scan_pop);
      end else if (cmd.pop) begin
         probes_ff <= probes_ff + C11'(1);
      end else if (range_done) begin
         case (cnt_new)
            2'd0:    idle_ff <= idle_ff + C11'(1);
            2'd1:    success_ff <= success_ff + C11'(1);
            default: coll_ff <= coll_ff + C10'(1);
         endcase
      end
   end

   assign sts.last_row = (rows_left_ff == ROWS_W'(1));
   assign sts.range_done = range_done;
   assign sts.walk_all_done = range_done && (stk_top_ff == '0) && !push;

   assign rsp_walk_kind = kind_ff;
   assign rsp_probe_count = probes_ff;
   assign rsp_success_count = success_ff;
   assign rsp_idle_count = idle_ff;
   assign rsp_collision_count = coll_ff;

   // Checks
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      stk_top_ff <= STK_AW'(STK_DEPTH))
      else $error("range stack overflow");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> stk_top_ff != '0)
      else $error("pop from empty range stack");

   a_scan_no_coll: assert property (@(posedge clock) disable iff (reset)
      kind_ff |-> coll_ff == '0)
      else $error("collision counted during scan");

   a_scan_sum: assert property (@(posedge clock) disable iff (reset)
      kind_ff |-> probes_ff == C11'(success_ff + idle_ff))
      else $error("scan probe count mismatch");

   a_cnt_sat: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2)
      else $error("tag count above saturation");

endmodule

// File: rtl/tree_walk_anticollision_stats.sv
// Top level: binary tree-walk anticollision statistics over a tag presence bitmap.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low; busy stays high until the
// item is finished. A clear never raises busy, and a mark reads its bitmap row
// and then writes it back. A scan reads every 32-slot bitmap row in turn
// (2^(depth-5) rows, at least one) before it reports. A tree walk pops each
// probe's range off the range stack and then reads the bitmap rows for that
// probe, one row at a time: the single read port of the bitmap memory sets the
// pace. Each run ends with one result on the rsp_ ports, marked by rsp_valid for
// exactly one cycle; the receiver must take it then. The depth register may be
// written only while busy is low; it is read when each item is taken and at each scan row.

module tree_walk_anticollision_stats (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_action,
   input  logic [twac_pkg::LEAF_W-1:0]       req_leaf_index,
   input  logic                              csr_wr_en,
   input  logic [twac_pkg::DEPTH_W-1:0]      csr_wr_data,
   output logic                              rsp_valid,
   output logic                              rsp_walk_kind,
   output logic [twac_pkg::CNT11_W-1:0]      rsp_probe_count,
   output logic [twac_pkg::CNT11_W-1:0]      rsp_success_count,
   output logic [twac_pkg::CNT11_W-1:0]      rsp_idle_count,
   output logic [twac_pkg::CNT10_W-1:0]      rsp_collision_count
);

   twac_pkg::cmd_type cmd;
   twac_pkg::sts_type sts;

   twac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   twac_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_leaf_index      (req_leaf_index),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_walk_kind       (rsp_walk_kind),
      .rsp_probe_count     (rsp_probe_count),
      .rsp_success_count   (rsp_success_count),
      .rsp_idle_count      (rsp_idle_count),
      .rsp_collision_count (rsp_collision_count)
   );

endmodule

// File: tb/tb_tree_walk_anticollision_stats.sv
// Self-checking testbench for the tree-walk anticollision statistics block.
`timescale 1ns / 1ps

module tb_tree_walk_anticollision_stats;

   localparam int CNT11_W = twac_pkg::CNT11_W;
   localparam int CNT10_W = twac_pkg::CNT10_W;
   localparam int LEAF_W = twac_pkg::LEAF_W;
   localparam int DEPTH_W = twac_pkg::DEPTH_W;
   localparam int MAX_DEPTH = twac_pkg::MAX_DEPTH;
   localparam int SLOT_TOTAL = twac_pkg::SLOT_TOTAL;

   // Counts of one walk or scan run
   typedef struct packed {
      logic               walk_kind;
      logic [CNT11_W-1:0] probes;
      logic [CNT11_W-1:0] successes;
      logic [CNT11_W-1:0] idles;
      logic [CNT10_W-1:0] collisions;
   } run_stats_type;

   // DUT ports
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_action = twac_pkg::ACT_MARK;
   logic [LEAF_W-1:0]  req_leaf_index = '0;
   logic               csr_wr_en = 1'b0;
   logic [DEPTH_W-1:0] csr_wr_data = '0;
   logic               rsp_valid;
   logic               rsp_walk_kind;
   logic [CNT11_W-1:0] rsp_probe_count;
   logic [CNT11_W-1:0] rsp_success_count;
   logic [CNT11_W-1:0] rsp_idle_count;
   logic [CNT10_W-1:0] rsp_collision_count;

   // Predictor state
   bit                 tag_map [SLOT_TOTAL];
   logic [DEPTH_W-1:0] depth_setting = twac_pkg::DEPTH_RESET;
   run_stats_type      stats_due [$];
   int unsigned        sender_gap_pct = 0;
   int unsigned        errors = 0;

   tree_walk_anticollision_stats u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_leaf_index      (req_leaf_index),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_walk_kind       (rsp_walk_kind),
      .rsp_probe_count     (rsp_probe_count),
      .rsp_success_count   (rsp_success_count),
      .rsp_idle_count      (rsp_idle_count),
      .rsp_collision_count (rsp_collision_count)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // depth above the maximum saturates
   function automatic int unsigned active_depth();
      return (depth_setting > DEPTH_W'(MAX_DEPTH)) ? MAX_DEPTH : 32'(depth_setting);
   endfunction

   // tags in [base, base + 2^lvl), saturating at two
   function automatic int unsigned tags_in_range(input int unsigned base,
                                                 input int unsigned lvl);
      int unsigned n;
      int unsigned span;
      n = 0;
      span = 1 << lvl;
      for (int unsigned i = 0; i < span && n < 2; i++)
         n += 32'(tag_map[(base + i) & (SLOT_TOTAL - 1)]);
      return n;
   endfunction

   // root-first binary splitting, lower half probed first
   function automatic run_stats_type walk_stats();
      run_stats_type s;
      int unsigned   stk_base [MAX_DEPTH + 1];
      int unsigned   stk_lvl [MAX_DEPTH + 1];
      int unsigned   top;
      int unsigned   base;
      int unsigned   lvl;
      int unsigned   n;
      s = '0;
      stk_base[0] = 0;
      stk_lvl[0] = active_depth();
      top = 1;
      while (top > 0) begin
         top--;
         base = stk_base[top];
         lvl = stk_lvl[top];
         s.probes = s.probes + 1'b1;
         n = tags_in_range(base, lvl);
         if (n == 0) begin
            s.idles = s.idles + 1'b1;
         end else if (n == 1) begin
            s.successes = s.successes + 1'b1;
         end else begin
            s.collisions = s.collisions + 1'b1;
            if (lvl > 0 && top + 2 <= MAX_DEPTH + 1) begin
               stk_base[top] = base + (1 << (lvl - 1));
               stk_lvl[top] = lvl - 1;
               stk_base[top + 1] = base;
               stk_lvl[top + 1] = lvl - 1;
               top += 2;
            end
         end
      end
      return s;
   endfunction

   // one probe per active slot
   function automatic run_stats_type scan_stats();
      run_stats_type s;
      s = '0;
      s.walk_kind = 1'b1;
      for (int unsigned i = 0; i < (1 << active_depth()); i++) begin
         s.probes = s.probes + 1'b1;
         if (tag_map[i])
            s.successes = s.successes + 1'b1;
         else
            s.idles = s.idles + 1'b1;
      end
      return s;
   endfunction

   // apply one accepted item to the predictor
   function automatic void predict_item(input twac_pkg::action_type act,
                                        input logic [LEAF_W-1:0] leaf);
      case (act)
         twac_pkg::ACT_MARK: begin
            if (32'(leaf) < (1 << active_depth()))
               tag_map[leaf] = 1'b1;
         end
         twac_pkg::ACT_CLEAR: begin
            tag_map = '{default: 1'b0};
         end
         twac_pkg::ACT_WALK: begin
            stats_due.push_back(walk_stats());
         end
         default: begin
            stats_due.push_back(scan_stats());
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // compare each result with the oldest expectation
   always @(posedge clock) begin : check_results
      run_stats_type want;
      if (!reset && rsp_valid) begin
         if (stats_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, got probes %0d",
                     $time, rsp_probe_count);
            errors++;
         end else begin
            want = stats_due.pop_front();
            check_field("walk_kind", 32'(want.walk_kind), 32'(rsp_walk_kind));
            check_field("probe_count", 32'(want.probes), 32'(rsp_probe_count));
            check_field("success_count", 32'(want.successes), 32'(rsp_success_count));
            check_field("idle_count", 32'(want.idles), 32'(rsp_idle_count));
            check_field("collision_count", 32'(want.collisions),
                        32'(rsp_collision_count));
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   // present one item, hold it until taken; start stays high afterwards
   task automatic send_item(input twac_pkg::action_type act,
                            input logic [LEAF_W-1:0] leaf);
      @(negedge clock);
      while ($urandom_range(99) < sender_gap_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_action = act;
      req_leaf_index = leaf;
      do @(posedge clock); while (busy);
      predict_item(act, leaf);
   endtask

   // stop sending and wait until every run has reported and marks have settled
   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      do @(posedge clock); while (busy || stats_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_depth(input logic [DEPTH_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(posedge clock);
      depth_setting = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic logic [DEPTH_W-1:0] pick_depth();
      case ($urandom_range(9))
         0: return 4'd0;
         1: return 4'd1;
         2: return twac_pkg::DEPTH_RESET;
         3: return DEPTH_W'($urandom_range(15, 11));
         default: return DEPTH_W'($urandom_range(7, 2));
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   // reset depth: empty map, edge slots, repeated mark, clear
   task automatic test_full_depth_basics();
      sender_gap_pct = 0;
      send_item(twac_pkg::ACT_WALK, '0);
      send_item(twac_pkg::ACT_SCAN, '1);
      send_item(twac_pkg::ACT_MARK, 10'd0);
      send_item(twac_pkg::ACT_MARK, 10'd1023);
      send_item(twac_pkg::ACT_MARK, 10'd1023);
      send_item(twac_pkg::ACT_WALK, '0);
      send_item(twac_pkg::ACT_SCAN, '0);
      send_item(twac_pkg::ACT_CLEAR, '1);
      send_item(twac_pkg::ACT_WALK, '0);
   endtask

   // depth extremes, saturation, out-of-range marks, depth change keeping marks
   task automatic test_depth_register();
      write_depth(4'd0);
      send_item(twac_pkg::ACT_MARK, 10'd1);
      send_item(twac_pkg::ACT_MARK, 10'd0);
      send_item(twac_pkg::ACT_WALK, '0);
      send_item(twac_pkg::ACT_SCAN, '0);
      write_depth(4'd15);
      send_item(twac_pkg::ACT_MARK, 10'd1023);
      send_item(twac_pkg::ACT_WALK, '0);
      write_depth(4'd2);
      send_item(twac_pkg::ACT_SCAN, '0);
      send_item(twac_pkg::ACT_MARK, 10'd1);
      send_item(twac_pkg::ACT_MARK, 10'd2);
      send_item(twac_pkg::ACT_MARK, 10'd3);
      send_item(twac_pkg::ACT_WALK, '0);
   endtask

   // mostly clear/mark/run sequences with random content, plus raw noise
   task automatic test_random_traffic(input int unsigned gap_pct, input int unsigned quota);
      int unsigned          sent;
      int unsigned          slots;
      int unsigned          marks;
      twac_pkg::action_type act;
      logic [LEAF_W-1:0]    leaf;
      sender_gap_pct = gap_pct;
      sent = 0;
      while (sent < quota) begin
         if ($urandom_range(99) < 30)
            write_depth(pick_depth());
         slots = 1 << active_depth();
         if ($urandom_range(99) < 75) begin
            if ($urandom_range(1)) begin
               send_item(twac_pkg::ACT_CLEAR, LEAF_W'($urandom_range(1023)));
               sent++;
            end
            if (slots <= 32 && $urandom_range(9) == 0) begin
               // every active slot present
               for (int unsigned i = 0; i < slots; i++) begin
                  send_item(twac_pkg::ACT_MARK, LEAF_W'(i));
                  sent++;
               end
            end else begin
               marks = $urandom_range((slots < 12) ? slots + 1 : 12);
               repeat (marks) begin
                  send_item(twac_pkg::ACT_MARK, LEAF_W'($urandom_range(slots - 1)));
                  sent++;
               end
            end
            send_item($urandom_range(1) ? twac_pkg::ACT_WALK : twac_pkg::ACT_SCAN,
                      LEAF_W'($urandom_range(1023)));
            sent++;
         end else begin
            repeat ($urandom_range(4, 1)) begin
               act = twac_pkg::action_type'($urandom_range(3));
               leaf = LEAF_W'($urandom_range(1023));
               send_item(act, leaf);
               sent++;
            end
         end
         if ($urandom_range(99) < 10)
            wait_drained();
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      tag_map = '{default: 1'b0};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_full_depth_basics();
      test_depth_register();
      test_random_traffic(26, 90);
      test_random_traffic(83, 90);
      test_random_traffic(0, 90);
      wait_drained();
      repeat (64) @(posedge clock);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// File: tree_walk_anticollision_stats.f
rtl/twac_pkg.sv
rtl/twac_ctrl.sv
rtl/twac_dp.sv
rtl/tree_walk_anticollision_stats.sv
tb/tb_tree_walk_anticollision_stats.sv
